FILE: src/prwc_pkg.sv
// Shared types and constants of the protected ROM write combiner.
package prwc_pkg;

    localparam int ROM_BYTES = 1024;
    localparam int ROM_WORDS = (ROM_BYTES + 7) / 8;
    localparam int WORD_AW   = (ROM_WORDS > 1) ? $clog2(ROM_WORDS) : 1;
    localparam int WORD_W    = 64;
    localparam int BYTE_W    = 8;
    localparam int LANE_W    = 3;
    localparam int ADDR_W    = 16;
    localparam int MASK_W    = 10;

    // Address limit, one bit wider than the address so 65536 fits.
    localparam logic [ADDR_W:0] ROM_LIMIT = (ADDR_W + 1)'(ROM_BYTES);

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ZERO  = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_OTHER = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_FLUSH,
        CMD_PASS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic [WORD_AW-1:0]      word;
        logic [LANE_W-1:0]       lane;
        logic [BYTE_W-1:0]       wbyte;
        logic                    acc;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_back_state;

endpackage

FILE: src/prwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/prwc_front.sv
// Front end: configuration registers, input item intake and write protection check.
module prwc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [prwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prwc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [prwc_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // rom_address[15:0], write_byte[23:16]
    input  logic [prwc_pkg::IN_TUSER_W-1:0]    i_s_tuser,  // req_type[1:0]
    input  logic                               i_q_full,
    output logic                               o_push,
    output prwc_pkg::t_cmd                     o_cmd
);
    import prwc_pkg::*;

    logic              r_write_protect;
    logic [MASK_W-1:0] r_protect_mask;
    logic              r_protect_zero;

    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wbyte;
    t_req              req;
    logic              in_range;
    logic              refused;
    t_cmd              cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_protect <= 1'b1;
            r_protect_mask  <= '1;
            r_protect_zero  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WRITE_PROTECT: r_write_protect <= i_cfg_data[0];
                CFG_PROTECT_MASK:  r_protect_mask  <= i_cfg_data[MASK_W-1:0];
                CFG_PROTECT_ZERO:  r_protect_zero  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign addr     = i_s_tdata[ADDR_W-1:0];
    assign wbyte    = i_s_tdata[ADDR_W +: BYTE_W];
    assign req      = t_req'(i_s_tuser);
    assign in_range = {1'b0, addr} < ROM_LIMIT;
    assign refused  = r_write_protect || !in_range
                   || ((addr & ADDR_W'(r_protect_mask)) != '0)
                   || ((addr == '0) && r_protect_zero);

    always_comb begin
        cmd       = '0;
        cmd.kind  = CMD_PASS;
        cmd.word  = addr[LANE_W +: WORD_AW];
        cmd.lane  = addr[LANE_W-1:0];
        cmd.wbyte = wbyte;
        cmd.acc   = 1'b1;
        unique case (req)
            REQ_READ: begin
                if (in_range) begin
                    cmd.kind = CMD_READ;
                end
            end
            REQ_WRITE: begin
                if (refused) begin
                    cmd.acc = 1'b0;
                end else begin
                    cmd.kind = CMD_WRITE;
                end
            end
            REQ_FLUSH: cmd.kind = CMD_FLUSH;
            REQ_OTHER: ;
        endcase
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;
    assign o_cmd      = cmd;

endmodule

FILE: src/prwc_queue.sv
// Short command queue between the front end and the back end.
module prwc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prwc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output prwc_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import prwc_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr;
    logic [Q_PW:0]   r_count;

    function automatic logic [Q_PW-1:0] ptr_inc(input logic [Q_PW-1:0] p);
        ptr_inc = (p == Q_PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = r_count == (Q_PW + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PW + 1)'(Q_DEPTH))
        else $error("queue count overflow");

endmodule

FILE: src/prwc_back.sv
// Back end: ROM store, write-combining line and result register.
module prwc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  prwc_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [prwc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,  // read_data[7:0]
    output logic [prwc_pkg::OUT_TUSER_W-1:0]   o_m_tuser   // accepted[0]
);
    import prwc_pkg::*;

    t_back_state        r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_data, n_out_data;
    logic               r_out_acc, n_out_acc;
    logic               r_line_valid, n_line_valid;
    logic [WORD_AW-1:0] r_line_index, n_line_index;
    logic [WORD_W-1:0]  r_line_data, n_line_data;
    logic               r_rd_vld, n_rd_vld;
    logic [ROM_WORDS-1:0] r_wvalid;

    logic               out_free;
    logic               pop;
    logic               ram_we;
    logic               ram_re;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  load_base;

    prwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_line_index),
        .i_wdata (r_line_data),
        .i_re    (ram_re),
        .i_raddr (i_cmd.word),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || i_m_tready;
    // Words never written back read as zero.
    assign load_base = r_rd_vld ? ram_rdata : '0;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_acc    = r_out_acc;
        n_line_valid = r_line_valid;
        n_line_index = r_line_index;
        n_line_data  = r_line_data;
        n_rd_vld     = r_rd_vld;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    unique case (i_cmd.kind)
                        CMD_READ: begin
                            ram_re   = 1'b1;
                            n_rd_vld = r_wvalid[i_cmd.word];
                            n_state  = ST_READ;
                        end
                        CMD_WRITE: begin
                            if (r_line_valid && r_line_index == i_cmd.word) begin
                                n_line_data[{i_cmd.lane, 3'b000} +: BYTE_W] = i_cmd.wbyte;
                                pop         = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                                n_out_acc   = 1'b1;
                            end else begin
                                // write back the old line and fetch the new word together
                                ram_we       = r_line_valid;
                                ram_re       = 1'b1;
                                n_rd_vld     = r_wvalid[i_cmd.word];
                                n_line_valid = 1'b0;
                                n_state      = ST_LOAD;
                            end
                        end
                        CMD_FLUSH: begin
                            ram_we       = r_line_valid;
                            n_line_valid = 1'b0;
                            pop          = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_data   = '0;
                            n_out_acc    = 1'b1;
                        end
                        CMD_PASS: begin
                            pop         = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_acc   = i_cmd.acc;
                        end
                    endcase
                end
            end
            ST_READ: begin
                pop         = 1'b1;
                n_out_valid = 1'b1;
                n_out_data  = load_base[{i_cmd.lane, 3'b000} +: BYTE_W];
                n_out_acc   = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_LOAD: begin
                n_line_data  = load_base;
                n_line_data[{i_cmd.lane, 3'b000} +: BYTE_W] = i_cmd.wbyte;
                n_line_index = i_cmd.word;
                n_line_valid = 1'b1;
                pop          = 1'b1;
                n_out_valid  = 1'b1;
                n_out_data   = '0;
                n_out_acc    = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_line_valid <= 1'b0;
            r_wvalid     <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_line_valid <= n_line_valid;
            if (ram_we) begin
                r_wvalid[r_line_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_acc    <= n_out_acc;
        r_line_index <= n_line_index;
        r_line_data  <= n_line_data;
        r_rd_vld     <= n_rd_vld;
    end

    assign o_cmd_pop  = pop;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_acc;

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_out_valid)
        else $error("command retired without a result");

    a_wait_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_LOAD) |-> $past(r_state) == ST_IDLE)
        else $error("wait state not entered from idle");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !ram_we)
        else $error("store written during a read");

    a_load_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> r_line_valid)
        else $error("line not valid after load");

endmodule

FILE: src/protected_rom_write_combiner.sv
// Top level of the protected ROM write combiner.
//
// Emulated 1024-byte ROM held as 64-bit words, with write protection and a
// one-line write-combining buffer.
// Input item (s side): tuser = request kind (read, write, flush), tdata = byte
// address and write byte. Result item (m side): tdata = read byte, tuser = accepted.
// Every input item yields exactly one result item, in order.
// Configuration is written through the cfg channel (index, data); it is always
// ready and must only be written while the block is idle.
// Timing: the front end checks protection and queues a command in the cycle the
// item is accepted; the back end then finishes a flush, a refused or ignored
// request and a write to the buffered word straight from idle, and a read or
// a write to another word via a wait state, set by the single store RAM: a
// write-back and the new word's load share its one write and one read port, and
// read data is registered. The result appears in the cycle after the back end ends.
// A two-entry command queue lets the input side keep accepting while the back
// end or the receiver stalls; when the result register is held by the receiver
// the back end waits and the queue fills, then tready drops.
// Reset clears the store at once (per-word valid bits, no clearing pass),
// empties the line and queue, and sets all protection on.
module protected_rom_write_combiner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [prwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prwc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [prwc_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // rom_address[15:0], write_byte[23:16]
    input  logic [prwc_pkg::IN_TUSER_W-1:0]    i_s_tuser,  // req_type[1:0]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [prwc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,  // read_data[7:0]
    output logic [prwc_pkg::OUT_TUSER_W-1:0]   o_m_tuser   // accepted[0]
);
    import prwc_pkg::*;

    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    prwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    prwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    prwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
